@@ design/mbpu_pkg.sv @@
// ----------------------------------------------------------------------------
// mbpu_pkg
// Shared types and constants for the mono bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package mbpu_pkg;

    // Largest image width or height; larger sizes saturate to this value
    localparam logic [8:0] MAX_DIM   = 9'd128;

    // Pixels packed into one data byte
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // One packed image byte with its image header fields
    typedef struct packed {
        logic       first;
        logic [6:0] origin_x;
        logic [6:0] origin_y;
        logic [7:0] image_width;
        logic [7:0] image_height;
        logic [7:0] data_byte;
    } pix_in_t;

    // One set pixel in screen coordinates
    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       last;
    } pix_out_t;

    // Byte sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SCAN = 3'b100
    } seq_state_t;

endpackage

@@ design/mbpu_out_reg.sv @@
// ----------------------------------------------------------------------------
// mbpu_out_reg
// Output register for pixel results; decouples the scanner from the
// downstream stall.
// ----------------------------------------------------------------------------
module mbpu_out_reg
    import mbpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  pix_out_t load_data,
    output logic     load_ready,
    output logic     dst_valid,
    input  logic     dst_stall,
    output pix_out_t dst_data
);

    logic     valid_reg;
    logic     valid_next;
    pix_out_t data_reg;

    // Accept a new result when empty or when the held one leaves this cycle
    assign load_ready = !valid_reg || !dst_stall;

    // Set on load, drop once the transaction completes
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!dst_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

endmodule

@@ design/mono_bitmap_pixel_unpacker.sv @@
// ----------------------------------------------------------------------------
// mono_bitmap_pixel_unpacker
// Unpacks one-bit-per-pixel image bytes, MSB first, rows padded to whole
// bytes, and emits the screen coordinate of every set pixel.
// ----------------------------------------------------------------------------
// Flow: a taken byte passes ST_LOAD, then ST_SCAN while an image is active;
//   each set pixel goes through the output register. No new byte is taken
//   until the scan ends; a byte scans only the pixels left in the row, at most
//   8, and the bit scanner steps one pixel per cycle, holding while dst_stall blocks a set pixel.
// Reset: counters, origin and size clear; no image is active until a byte
//   marked first arrives; output register empties.
// ----------------------------------------------------------------------------
module mono_bitmap_pixel_unpacker
    import mbpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  pix_in_t  src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output pix_out_t dst_data
);

    seq_state_t state_reg, state_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [6:0] base_x_reg, base_x_next;
    logic [6:0] base_y_reg, base_y_next;
    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic       done_reg, done_next;
    logic [7:0] byte_reg, byte_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       row_end_reg, row_end_next;

    logic       src_take;
    logic [7:0] width_clamp;
    logic [7:0] height_clamp;
    logic [7:0] remain;
    logic [3:0] take_bits;
    logic [7:0] keep_mask;
    logic [7:0] row_inc;
    logic       pix_set;
    logic       emit;
    logic       step;
    logic       load_ready;
    pix_out_t   pix;

    assign src_stall = (state_reg != ST_IDLE);
    assign src_take  = src_valid && !src_stall;

    // Saturate header sizes to the largest supported dimension
    assign width_clamp  = ({1'b0, src_data.image_width} > MAX_DIM) ?
                          MAX_DIM[7:0] : src_data.image_width;
    assign height_clamp = ({1'b0, src_data.image_height} > MAX_DIM) ?
                          MAX_DIM[7:0] : src_data.image_height;

    // Pixels of this byte that still belong to the current row
    assign remain    = width_reg - col_reg;
    assign take_bits = (remain >= {4'd0, BYTE_BITS}) ? BYTE_BITS : remain[3:0];
    assign keep_mask = 8'hFF << (BYTE_BITS - take_bits);

    // Scan step: one pixel per cycle, hold while a set pixel cannot leave
    assign pix_set = byte_reg[7];
    assign step    = (state_reg == ST_SCAN) && (!pix_set || load_ready);
    assign emit    = step && pix_set;
    assign row_inc = row_reg + 8'd1;

    assign pix.pixel_x = {1'b0, base_x_reg} + col_reg;
    assign pix.pixel_y = {1'b0, base_y_reg} + row_reg;
    assign pix.last    = (byte_reg[6:0] == 7'd0);

    // Sequencer and image state
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        base_x_next  = base_x_reg;
        base_y_next  = base_y_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        done_next    = done_reg;
        byte_next    = byte_reg;
        cnt_next     = cnt_reg;
        row_end_next = row_end_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_take)
                begin
                    byte_next  = src_data.data_byte;
                    state_next = ST_LOAD;
                    if (src_data.first)
                    begin
                        base_x_next = src_data.origin_x;
                        base_y_next = src_data.origin_y;
                        width_next  = width_clamp;
                        height_next = height_clamp;
                        col_next    = 8'd0;
                        row_next    = 8'd0;
                        done_next   = (width_clamp == 8'd0) || (height_clamp == 8'd0);
                    end
                end
            end
            ST_LOAD:
            begin
                if (done_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    byte_next    = byte_reg & keep_mask;
                    cnt_next     = take_bits;
                    row_end_next = (remain <= {4'd0, BYTE_BITS});
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    cnt_next  = cnt_reg - 4'd1;
                    col_next  = col_reg + 8'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        state_next = ST_IDLE;
                        if (row_end_reg)
                        begin
                            col_next = 8'd0;
                            row_next = row_inc;
                            if (row_inc >= height_reg)
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_reg     <= 8'd0;
            row_reg     <= 8'd0;
            base_x_reg  <= 7'd0;
            base_y_reg  <= 7'd0;
            width_reg   <= 8'd0;
            height_reg  <= 8'd0;
            done_reg    <= 1'b1;
            cnt_reg     <= 4'd0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            base_x_reg  <= base_x_next;
            base_y_reg  <= base_y_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            row_end_reg <= row_end_next;
        end
    end

    // Hold the byte being scanned
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    mbpu_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .load_data  (pix),
        .load_ready (load_ready),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_data   (dst_data)
    );

    // Scanning only happens inside an active image
    a_scan_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !done_reg)
        else $error("scan while no image is active");

    // Column offset stays inside the row while scanning
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (col_reg < width_reg))
        else $error("column offset past image width");

    // Bit count is between one and a full byte while scanning
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg != 4'd0 && cnt_reg <= BYTE_BITS))
        else $error("scan bit count out of range");

    // A held set pixel does not advance the column
    a_hold_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && pix_set && !load_ready) |=> $stable(col_reg))
        else $error("column advanced while a pixel was blocked");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono bitmap pixel unpacker: directed images
// for rows, padding, empty and saturated sizes, then random images with
// random content, bursty input, receiver stalls and one long hold-off.
// Each accepted byte is run through a local pixel predictor and every
// emitted pixel is compared in order against the predicted pixels.
// ----------------------------------------------------------------------------
module tb_top;

    import mbpu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 90;
    localparam int MAX_REPORTS    = 50;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    pix_in_t  src_data  = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    pix_out_t dst_data;

    // Predicted pixels, oldest first
    pix_out_t pixel_q[$];

    // Local copy of the unpacker state
    logic [7:0] col_off;
    logic [7:0] row_off;
    logic [6:0] org_x;
    logic [6:0] org_y;
    logic [7:0] img_w;
    logic [7:0] img_h;
    logic       no_image;

    int  err_count  = 0;
    int  burst_left = 0;
    int  idle_count = 0;
    bit  hold_req   = 1'b0;
    int  hold_left  = 0;
    int  stall_mode = 0;
    int  mode_cnt   = 0;

    mono_bitmap_pixel_unpacker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Saturate an image dimension to the largest supported size
    function automatic logic [7:0] clamp_dim(input logic [7:0] v);
        if (v > MAX_DIM)
            return MAX_DIM[7:0];
        return v;
    endfunction

    // Return an image byte; header fields are random unless it opens an image
    function automatic pix_in_t make_byte(input logic first, input logic [6:0] ox,
                                          input logic [6:0] oy, input logic [7:0] w,
                                          input logic [7:0] h, input logic [7:0] data);
        pix_in_t it;
        it.first        = first;
        it.origin_x     = first ? ox : 7'($urandom);
        it.origin_y     = first ? oy : 7'($urandom);
        it.image_width  = first ? w  : 8'($urandom);
        it.image_height = first ? h  : 8'($urandom);
        it.data_byte    = data;
        return it;
    endfunction

    function automatic logic [7:0] random_data();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Advance the predictor by one byte and queue the pixels it sets
    task automatic predict_pixels(input pix_in_t it);
        pix_out_t px[8];
        int       n;
        n = 0;
        if (it.first)
        begin
            org_x    = it.origin_x;
            org_y    = it.origin_y;
            img_w    = clamp_dim(it.image_width);
            img_h    = clamp_dim(it.image_height);
            col_off  = '0;
            row_off  = '0;
            no_image = (img_w == 0) || (img_h == 0);
        end
        for (int b = 0; b < 8; b++)
        begin
            if (no_image)
                break;
            if (it.data_byte[7 - b])
            begin
                px[n].pixel_x = {1'b0, org_x} + col_off;
                px[n].pixel_y = {1'b0, org_y} + row_off;
                px[n].last    = 1'b0;
                n++;
            end
            col_off = col_off + 8'd1;
            // Skip the row padding once the row is complete
            if (col_off >= img_w)
            begin
                col_off = '0;
                row_off = row_off + 8'd1;
                if (row_off >= img_h)
                    no_image = 1'b1;
                break;
            end
        end
        if (n > 0)
            px[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pixel_q.push_back(px[i]);
    endtask

    // Offer one byte in bursts with random gaps; predict on acceptance
    task automatic send_byte(input pix_in_t it);
        if (burst_left == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        do
            @(posedge clk);
        while (src_stall);
        predict_pixels(it);
        burst_left--;
    endtask

    // Send a whole image, optionally cut short after a given number of bytes
    task automatic send_image(input logic [6:0] ox, input logic [6:0] oy,
                              input logic [7:0] w, input logic [7:0] h,
                              input int max_bytes, output int sent);
        int row_bytes;
        int total;
        row_bytes = (clamp_dim(w) + 7) / 8;
        total     = row_bytes * clamp_dim(h);
        if (total == 0)
            total = 1;
        if (total > max_bytes)
            total = max_bytes;
        for (int k = 0; k < total; k++)
            send_byte(make_byte(k == 0, ox, oy, w, h, random_data()));
        sent = total;
    endtask

    // Bytes before any image and after the image ends are dropped
    task automatic test_no_image;
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
        send_byte(make_byte(1'b1, 7'd0, 7'd0, 8'd8, 8'd1, 8'hFF));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
    endtask

    // Empty bytes give no pixels; sparse bytes give one or two pixels each
    task automatic test_empty_and_sparse;
        send_byte(make_byte(1'b1, 7'd10, 7'd20, 8'd16, 8'd2, 8'h00));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'h81));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'h01));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'h80));
    endtask

    // Row end inside a byte skips the padding bits
    task automatic test_row_padding;
        send_byte(make_byte(1'b1, 7'd3, 7'd4, 8'd3, 8'd3, 8'hFF));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
        send_byte(make_byte(1'b1, 7'd1, 7'd1, 8'd1, 8'd2, 8'h7F));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hC0));
    endtask

    // Zero width or height leaves no image active
    task automatic test_zero_size;
        send_byte(make_byte(1'b1, 7'd5, 7'd5, 8'd0, 8'd5, 8'hFF));
        send_byte(make_byte(1'b1, 7'd5, 7'd5, 8'd5, 8'd0, 8'hFF));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'hFF));
    endtask

    // Oversized dimensions saturate; origin at its maximum
    task automatic test_saturation;
        send_byte(make_byte(1'b1, 7'd127, 7'd127, 8'd255, 8'd200, 8'hAA));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'h55));
        send_byte(make_byte(1'b1, 7'd127, 7'd0, 8'd129, 8'd128, 8'hFF));
    endtask

    // A new first byte restarts the counters mid-image
    task automatic test_restart;
        send_byte(make_byte(1'b1, 7'd0, 7'd0, 8'd8, 8'd4, 8'h0F));
        send_byte(make_byte(1'b1, 7'd5, 7'd9, 8'd1, 8'd1, 8'h80));
        send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'h80));
    endtask

    // Hold off the receiver while the sender keeps offering bytes
    task automatic test_backpressure;
        int sent;
        hold_req = 1'b1;
        send_image(7'd40, 7'd50, 8'd8, 8'd30, 30, sent);
    endtask

    // Random images with random content, truncations and stray bytes
    task automatic test_random_images;
        int          counted;
        int          sent;
        int          sel;
        int          limit;
        logic [7:0]  w;
        logic [7:0]  h;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 39);
            if (sel < 3)
            begin
                w = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(64, 128))
                                                : 8'($urandom_range(129, 255));
                h = 8'($urandom_range(1, 2));
            end
            else if (sel == 3)
            begin
                w = 8'($urandom_range(1, 8));
                h = 8'($urandom_range(64, 255));
            end
            else if (sel == 4)
            begin
                w = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
                h = (w == 0) ? 8'($urandom) : 8'd0;
            end
            else
            begin
                w = 8'($urandom_range(1, 24));
                h = 8'($urandom_range(1, 6));
            end
            // Cut some images short so that the next one interrupts them
            limit = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 1 << 20;
            send_image(7'($urandom), 7'($urandom), w, h, limit, sent);
            if (sel != 4)
                counted += sent;
            // Drop stray bytes after the image
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(make_byte(1'b0, 7'd0, 7'd0, 8'd0, 8'd0, 8'($urandom)));
        end
    endtask

    // Receiver stall pattern: random modes that change when mode_cnt wraps; long hold on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            dst_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            dst_stall <= 1'b1;
        end
        else
        begin
            mode_cnt++;
            if (mode_cnt >= 50)
            begin
                mode_cnt   = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       dst_stall <= 1'b0;
                1:       dst_stall <= ($urandom_range(0, 3) == 0);
                2:       dst_stall <= ($urandom_range(0, 9) < 6);
                default: dst_stall <= ((mode_cnt % 3) == 0);
            endcase
        end
    end

    // Compare each pixel transaction with the oldest prediction
    always @(posedge clk)
    begin
        pix_out_t exp_px;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0b",
                             $time, dst_data.pixel_x, dst_data.pixel_y, dst_data.last);
            end
            else
            begin
                exp_px = pixel_q.pop_front();
                if (dst_data !== exp_px)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b, actual x=%0d y=%0d last=%0b",
                                 $time, exp_px.pixel_x, exp_px.pixel_y, exp_px.last,
                                 dst_data.pixel_x, dst_data.pixel_y, dst_data.last);
                end
            end
        end
    end

    // End the run if no transaction completes for too long
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d pixels pending", $time, pixel_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int drain;
        col_off  = '0;
        row_off  = '0;
        org_x    = '0;
        org_y    = '0;
        img_w    = '0;
        img_h    = '0;
        no_image = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_image();
        test_empty_and_sparse();
        test_row_padding();
        test_zero_size();
        test_saturation();
        test_restart();
        test_backpressure();
        test_random_images();

        // Drain the remaining pixels, then let the block settle
        src_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ mono_bitmap_pixel_unpacker.f @@
design/mbpu_pkg.sv
design/mbpu_out_reg.sv
design/mono_bitmap_pixel_unpacker.sv
tb/tb_top.sv
